/* sv/lso_pkg.sv */
package lso_pkg;

  // Fixed field widths.
  localparam int IndexW = 12;
  localparam int RangeW = 16;
  localparam int StartW = 20;
  localparam int StepW  = 17;
  localparam int DistW  = 16;
  localparam int SpeedW = 6;
  localparam int RateW  = 8;
  localparam int ProdW  = IndexW + StepW;
  localparam int AngleW = ProdW + 2;

  // Samples with an index at or above this are ignored.
  localparam int MaxSamples = 4096;
  localparam int IdxCmpW    = 17;

  localparam int NumSectors = 5;

  localparam logic [RangeW-1:0] NoReturn = '1;

  // Sector edges in units of 2^-16 rad: 0.26, 0.78 and 1.57 rad.
  localparam logic signed [AngleW-1:0] BFront = AngleW'(17039);
  localparam logic signed [AngleW-1:0] BMid   = AngleW'(51118);
  localparam logic signed [AngleW-1:0] BSide  = AngleW'(102892);

  typedef enum logic [2:0] {
    SecFront      = 3'd0,
    SecFrontRight = 3'd1,
    SecRight      = 3'd2,
    SecFrontLeft  = 3'd3,
    SecLeft       = 3'd4
  } sector_t;

  typedef enum logic [2:0] {
    CfgAngleStart   = 3'd0,
    CfgAngleStep    = 3'd1,
    CfgStopDistance = 3'd2,
    CfgNearDistance = 3'd3,
    CfgClearDistance = 3'd4
  } cfg_reg_t;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = StartW;

  localparam logic [SpeedW-1:0] SpeedCruise = 6'd60;
  localparam logic [SpeedW-1:0] SpeedTurn   = 6'd20;
  localparam logic [SpeedW-1:0] SpeedStop   = 6'd0;

  localparam logic signed [RateW-1:0] RateFast = 8'sd90;
  localparam logic signed [RateW-1:0] RateSlow = 8'sd50;
  localparam logic signed [RateW-1:0] RateNone = 8'sd0;

  localparam logic signed [StartW-1:0] AngleStartReset = -20'sd205887;
  localparam logic [StepW-1:0]         AngleStepReset  = 17'd286;
  localparam logic [DistW-1:0]         StopReset       = 16'd500;
  localparam logic [DistW-1:0]         NearReset       = 16'd1000;
  localparam logic [DistW-1:0]         ClearReset      = 16'd2000;

  typedef struct packed {
    logic [IndexW-1:0] sample_index;
    logic [RangeW-1:0] range_mm;
    logic              range_valid;
    logic              last_sample;
  } sample_t;

  typedef struct packed {
    logic [SpeedW-1:0]        linear_speed;
    logic signed [RateW-1:0]  angular_rate;
    logic [RangeW-1:0]        front_min;
    logic [RangeW-1:0]        left_space;
    logic [RangeW-1:0]        right_space;
  } cmd_t;

endpackage

/* sv/lso_if.sv */
interface lso_sample_if import lso_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lso_cmd_if import lso_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/lidar_sector_obstacle_steer.sv */
// Lidar sector obstacle steering. The block takes one range sample per clock
// cycle and holds the running minimum of five angular sectors (front, front
// right, right, front left, left). A sample's angle is angle_start plus
// sample_index times angle_step in units of 2^-16 rad; sector edges are
// inclusive, so a sample on an edge lowers both neighbors. Samples that are
// flagged invalid, or whose index is 4096 or more, leave the minima alone.
// The sample marked last closes the scan: the block issues one steering
// command (cruise when the front is clear, otherwise a turn toward the side
// with the larger gap, faster when near and with zero forward speed when very
// near) and the minima start over. A sample goes through an input register
// and a sector-hit register before it reaches the minima, and the command is
// loaded into the output register when the last sample retires from the
// sector-hit register. Throughput is one sample per cycle; the input stalls
// only when a finished command is still waiting in the output register and
// the next scan end is already at the minima stage.
// Configuration registers should be written only while no sample is in
// flight.
module lidar_sector_obstacle_steer
  import lso_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  lso_sample_if.sink           sample_ch,
  lso_cmd_if.source            cmd_ch
);

  // Configuration registers.
  logic signed [StartW-1:0] angle_start;
  logic [StepW-1:0]         angle_step;
  logic [DistW-1:0]         stop_distance;
  logic [DistW-1:0]         near_distance;
  logic [DistW-1:0]         clear_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start    <= AngleStartReset;
      angle_step     <= AngleStepReset;
      stop_distance  <= StopReset;
      near_distance  <= NearReset;
      clear_distance <= ClearReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CfgAngleStart:    angle_start    <= $signed(cfg_data[StartW-1:0]);
        CfgAngleStep:     angle_step     <= cfg_data[StepW-1:0];
        CfgStopDistance:  stop_distance  <= cfg_data[DistW-1:0];
        CfgNearDistance:  near_distance  <= cfg_data[DistW-1:0];
        CfgClearDistance: clear_distance <= cfg_data[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Stage A holds the accepted sample, stage B holds the
  // sector hits and range, and the output register holds the command.
  logic    a_valid;
  sample_t a_item;
  logic    b_valid;
  logic    b_last;
  logic [RangeW-1:0]     b_range;
  logic [NumSectors-1:0] b_hit;
  logic    b_ok;
  logic    b_free;
  logic    a_move;

  // Stage B can retire unless it carries a scan end that the output
  // register cannot take this cycle.
  assign b_ok   = !b_valid || !b_last || !cmd_ch.valid || cmd_ch.ready;
  assign b_free = !b_valid || b_ok;
  assign a_move = a_valid && b_free;
  assign sample_ch.ready = !a_valid || b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      a_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      a_item <= sample_ch.data;
    end
  end

  // Angle of the sample in stage A and the sectors that contain it.
  logic [ProdW-1:0]         prod;
  logic signed [AngleW-1:0] angle;
  logic                     use_sample;
  logic [NumSectors-1:0]    hit;

  always_comb begin
    prod  = ProdW'(a_item.sample_index) * ProdW'(angle_step);
    angle = AngleW'(angle_start) + $signed({2'b00, prod});
    use_sample = a_item.range_valid &&
                 (IdxCmpW'(a_item.sample_index) < IdxCmpW'(MaxSamples));
    hit[SecFront]      = use_sample && (angle >= -BFront) && (angle <= BFront);
    hit[SecFrontRight] = use_sample && (angle >= -BMid) && (angle <= -BFront);
    hit[SecRight]      = use_sample && (angle >= -BSide) && (angle <= -BMid);
    hit[SecFrontLeft]  = use_sample && (angle >= BFront) && (angle <= BMid);
    hit[SecLeft]       = use_sample && (angle >= BMid) && (angle <= BSide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_move;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_last  <= a_item.last_sample;
      b_range <= a_item.range_mm;
      b_hit   <= hit;
    end
  end

  // Sector minima, updated as stage B retires.
  logic [RangeW-1:0] sector_min      [NumSectors];
  logic [RangeW-1:0] sector_min_next [NumSectors];
  logic              b_retire;

  assign b_retire = b_valid && b_ok;

  always_comb begin
    for (int k = 0; k < NumSectors; k++) begin
      sector_min_next[k] = (b_hit[k] && (b_range < sector_min[k])) ? b_range
                                                                   : sector_min[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumSectors; k++) sector_min[k] <= NoReturn;
    end else if (b_retire) begin
      for (int k = 0; k < NumSectors; k++) begin
        sector_min[k] <= b_last ? NoReturn : sector_min_next[k];
      end
    end
  end

  // Steering decision from the minima including the scan's final sample.
  cmd_t cmd_next;
  logic [RangeW-1:0] front;
  logic [RangeW-1:0] lgap;
  logic [RangeW-1:0] rgap;
  logic signed [RateW-1:0] turn;

  always_comb begin
    front = sector_min_next[SecFront];
    lgap  = (sector_min_next[SecFrontLeft] > sector_min_next[SecLeft]) ?
            sector_min_next[SecFrontLeft] : sector_min_next[SecLeft];
    rgap  = (sector_min_next[SecFrontRight] > sector_min_next[SecRight]) ?
            sector_min_next[SecFrontRight] : sector_min_next[SecRight];
    turn  = (front < near_distance) ? RateFast : RateSlow;
    cmd_next.front_min   = front;
    cmd_next.left_space  = lgap;
    cmd_next.right_space = rgap;
    if (front > clear_distance) begin
      cmd_next.linear_speed = SpeedCruise;
      cmd_next.angular_rate = RateNone;
    end else begin
      cmd_next.linear_speed = (front < stop_distance) ? SpeedStop : SpeedTurn;
      cmd_next.angular_rate = (lgap >= rgap) ? turn : -turn;
    end
  end

  // Output register.
  logic cmd_load;
  assign cmd_load = b_retire && b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_load) begin
      cmd_ch.valid <= 1'b1;
    end else if (cmd_ch.ready) begin
      cmd_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_ch.data <= cmd_next;
    end
  end

  // A scan end always leaves the front, left and right minima at the no-return value.
  assert property (@(posedge clk) disable iff (rst)
    cmd_load |=> (sector_min[SecFront] == NoReturn) && (sector_min[SecLeft] == NoReturn)
                 && (sector_min[SecRight] == NoReturn))
    else $error("sector minima not cleared after scan end");

  // The input stalls only when every stage is full, stage B holds a scan end and the output is blocked.
  assert property (@(posedge clk) disable iff (rst)
    !sample_ch.ready |-> a_valid && b_valid && b_last && cmd_ch.valid && !cmd_ch.ready)
    else $error("input stalled without a full pipeline");

  // Cruising never turns, and any other command always turns.
  assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid |-> ((cmd_ch.data.linear_speed == SpeedCruise) ==
                      (cmd_ch.data.angular_rate == RateNone)))
    else $error("speed and turn rate disagree");

  // A waiting command must not be overwritten.
  assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && !cmd_ch.ready |-> !cmd_load)
    else $error("command overwritten while stalled");

endmodule
